>>> src/addressed_display_frame_controller_defines.svh
// Assertion macros shared by the frame controller modules.
`ifndef ADDRESSED_DISPLAY_FRAME_CONTROLLER_DEFINES_SVH
`define ADDRESSED_DISPLAY_FRAME_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset on the module's clk and rst_n.
`define ADFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset on the module's clk and rst_n.
`define ADFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/adfc_pkg.sv
// Types, constants and helper functions of the addressed display frame controller.
package adfc_pkg;

    // Frame layout and character codes.
    localparam logic [7:0] HDR_BYTE     = 8'h7E;
    localparam logic [7:0] END_BYTE     = 8'h7F;
    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] CMD_DISPLAY  = 8'h30;
    localparam logic [7:0] CMD_SET_ID   = 8'h32;

    // Slot counter: slot 0 is the header, slot 8 the end byte.
    localparam int         CNT_W        = 4;
    localparam logic [CNT_W-1:0] LAST_SLOT = 4'd8;

    // Power-on device address, "00".
    localparam logic [15:0] ID_RESET    = 16'd12336;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Register map.
    localparam int  PADDR_W          = 3;
    localparam logic REG_POWER_ON_ID = 1'b0;

    // Output kinds.
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    // Input operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [3:0] SEL_NONE = 4'hF;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [7:0] segments;
        logic [3:0] digit_select;
        logic       last;
    } out_item_t;

    // One queued job: a scan output or a reply frame for an ID.
    typedef struct packed {
        logic        is_tick;
        logic [15:0] id;
        logic [7:0]  segments;
        logic [3:0]  digit_select;
    } job_t;

    // Configuration write toward the front.
    typedef struct packed {
        logic        en;
        logic [15:0] id;
    } cfg_wr_t;

    // Seven-segment pattern of a digit; values above nine are blank.
    function automatic logic [7:0] seg_pattern(input logic [7:0] v);
        logic [7:0] s;
        case (v)
            8'd0:    s = 8'hFC;
            8'd1:    s = 8'h60;
            8'd2:    s = 8'hDA;
            8'd3:    s = 8'hF2;
            8'd4:    s = 8'h66;
            8'd5:    s = 8'hB6;
            8'd6:    s = 8'hBE;
            8'd7:    s = 8'hE0;
            8'd8:    s = 8'hFE;
            8'd9:    s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Byte of a reply frame at a given beat.
    function automatic logic [7:0] reply_byte(input logic [CNT_W-1:0] beat,
                                              input logic [15:0] id);
        logic [7:0] b;
        case (beat)
            4'd0:    b = HDR_BYTE;
            4'd1:    b = id[15:8];
            4'd2:    b = id[7:0];
            4'd3:    b = CMD_SET_ID;
            4'd8:    b = END_BYTE;
            default: b = ASCII_ZERO;
        endcase
        return b;
    endfunction

endpackage

>>> src/adfc_front.sv
// Front end: collects frames, decodes commands, drives display state and queues jobs.
`include "addressed_display_frame_controller_defines.svh"

module adfc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  adfc_pkg::in_item_t in_item,
    input  adfc_pkg::cfg_wr_t cfg,
    input  logic              q_full,
    output logic              push,
    output adfc_pkg::job_t    push_job
);

    logic [adfc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]  fb_reg [1:7];
    logic [15:0] device_id_reg, device_id_next;
    logic [7:0]  digit_reg [0:3];
    logic [1:0]  scan_reg;

    logic        accept;
    logic        is_byte;
    logic        is_tick;
    logic        frame_done;
    logic        id_match;
    logic        data_zero;
    logic        end_ok;
    logic        do_display;
    logic        do_echo;
    logic        do_change;
    logic [7:0]  b;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign b        = in_item.rx_byte;
    assign is_byte  = accept && (in_item.op == adfc_pkg::OP_BYTE);
    assign is_tick  = accept && (in_item.op == adfc_pkg::OP_TICK);

    // Decode of a completed frame; the current byte is the end slot.
    assign frame_done = is_byte && (count_reg == adfc_pkg::LAST_SLOT);
    assign end_ok     = (b == adfc_pkg::END_BYTE);
    assign id_match   = ({fb_reg[1], fb_reg[2]} == device_id_reg);
    assign data_zero  = (fb_reg[4] == adfc_pkg::ASCII_ZERO) && (fb_reg[5] == adfc_pkg::ASCII_ZERO)
                     && (fb_reg[6] == adfc_pkg::ASCII_ZERO) && (fb_reg[7] == adfc_pkg::ASCII_ZERO);
    assign do_display = frame_done && end_ok && (fb_reg[3] == adfc_pkg::CMD_DISPLAY) && id_match;
    assign do_echo    = frame_done && end_ok && (fb_reg[3] == adfc_pkg::CMD_SET_ID) && data_zero;
    assign do_change  = frame_done && end_ok && (fb_reg[3] == adfc_pkg::CMD_SET_ID)
                     && !data_zero && id_match;

    // Slot counter: a bad header keeps collection at the first slot.
    always_comb
    begin
        count_next = count_reg;
        if (is_byte)
        begin
            if (count_reg == '0)
                count_next = (b == adfc_pkg::HDR_BYTE) ? adfc_pkg::CNT_W'(1) : '0;
            else if (count_reg == adfc_pkg::LAST_SLOT)
                count_next = '0;
            else
                count_next = count_reg + adfc_pkg::CNT_W'(1);
        end
    end

    // Device ID follows configuration writes and ID commands.
    always_comb
    begin
        device_id_next = device_id_reg;
        if (cfg.en)
            device_id_next = cfg.id;
        else if (do_echo)
            device_id_next = {fb_reg[1], fb_reg[2]};
        else if (do_change)
            device_id_next = {fb_reg[6], fb_reg[7]};
    end

    // Job toward the back: a scan output or a reply frame.
    always_comb
    begin
        push                  = is_tick || do_echo || do_change;
        push_job.is_tick      = is_tick;
        push_job.id           = device_id_next;
        push_job.segments     = adfc_pkg::seg_pattern(digit_reg[scan_reg]);
        push_job.digit_select = ~(4'b0001 << scan_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            device_id_reg <= adfc_pkg::ID_RESET;
            scan_reg      <= '0;
            for (int i = 0; i < 4; i++)
                digit_reg[i] <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            device_id_reg <= device_id_next;
            if (is_tick)
                scan_reg <= scan_reg + 2'd1;
            if (do_display)
            begin
                for (int i = 0; i < 4; i++)
                    digit_reg[i] <= fb_reg[4 + i] - adfc_pkg::ASCII_ZERO;
            end
        end
    end

    // Frame slots one to seven; the header and end bytes are checked on arrival.
    always_ff @(posedge clk)
    begin
        for (int i = 1; i < 8; i++)
        begin
            if (is_byte && (count_reg == adfc_pkg::CNT_W'(i)))
                fb_reg[i] <= b;
        end
    end

    `ADFC_ASSERT_IMP(a_count_range, 1'b1, count_reg <= adfc_pkg::LAST_SLOT, "slot count out of range")
    `ADFC_ASSERT_NXT(a_cfg_loads_id, cfg.en, device_id_reg == $past(cfg.id), "config write lost")
    `ADFC_ASSERT_IMP(a_one_decode, 1'b1, !(do_echo && do_change) && !(do_display && push),
                     "conflicting frame decode")

endmodule

>>> src/adfc_queue.sv
// Short job queue between the front and the back.
`include "addressed_display_frame_controller_defines.svh"

module adfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  adfc_pkg::job_t push_job,
    output logic           full,
    output logic           head_valid,
    output adfc_pkg::job_t head,
    input  logic           pop
);

    adfc_pkg::job_t                 q_reg [0:adfc_pkg::QDEPTH-1];
    logic [adfc_pkg::QAW-1:0]       wptr_reg;
    logic [adfc_pkg::QAW-1:0]       rptr_reg;
    logic [adfc_pkg::QCW-1:0]       cnt_reg;

    assign full       = (cnt_reg == adfc_pkg::QCW'(adfc_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + adfc_pkg::QAW'(1);
            if (pop)
                rptr_reg <= rptr_reg + adfc_pkg::QAW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + adfc_pkg::QCW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - adfc_pkg::QCW'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= push_job;
    end

    `ADFC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= adfc_pkg::QCW'(adfc_pkg::QDEPTH), "count overflow")
    `ADFC_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from empty queue")
    `ADFC_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")

endmodule

>>> src/adfc_back.sv
// Back end: expands queued jobs into result items behind an output register.
`include "addressed_display_frame_controller_defines.svh"

module adfc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  adfc_pkg::job_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output adfc_pkg::out_item_t out_item
);

    logic                       out_valid_reg, out_valid_next;
    adfc_pkg::out_item_t        out_item_reg, out_item_next;
    logic [adfc_pkg::CNT_W-1:0] beat_reg, beat_next;
    logic                       load;
    logic                       last_beat;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign load      = !out_valid_reg || !out_stall;
    assign last_beat = (beat_reg == adfc_pkg::LAST_SLOT);

    // Next result item and queue pop.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        beat_next      = beat_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (head.is_tick)
                begin
                    out_item_next.kind         = adfc_pkg::KIND_SCAN;
                    out_item_next.tx_byte      = '0;
                    out_item_next.segments     = head.segments;
                    out_item_next.digit_select = head.digit_select;
                    out_item_next.last         = 1'b1;
                    pop                        = 1'b1;
                end
                else
                begin
                    out_item_next.kind         = adfc_pkg::KIND_TX;
                    out_item_next.tx_byte      = adfc_pkg::reply_byte(beat_reg, head.id);
                    out_item_next.segments     = '0;
                    out_item_next.digit_select = adfc_pkg::SEL_NONE;
                    out_item_next.last         = last_beat;
                    pop                        = last_beat;
                    beat_next = last_beat ? '0 : beat_reg + adfc_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    `ADFC_ASSERT_IMP(a_beat_on_reply, beat_reg != '0, head_valid && !head.is_tick,
                     "reply beat without reply job")
    `ADFC_ASSERT_IMP(a_scan_is_last, out_valid_reg && (out_item_reg.kind == adfc_pkg::KIND_SCAN),
                     out_item_reg.last, "scan output not marked last")

endmodule

>>> src/addressed_display_frame_controller.sv
// Top level of the addressed display frame controller.
// Usage:
// The input channel (in_valid, in_stall, in_item) carries one item per accept:
// a received serial byte (op 0) or a display scan tick (op 1).
// The output channel (out_valid, out_stall, out_item) carries result items:
// a scan tick gives one scan output; a frame that sets or changes the ID gives
// nine reply bytes, the ninth marked last; other bytes give nothing.
// A result is written into the job queue and then into the output register. One
// input item is taken per cycle while the queue is not full; a reply frame
// leaves the output one byte per cycle while the output is not stalled.
// A four-entry job queue sits between the decoder and the output sequencer;
// in_stall rises only while it is full, so up to four reply or scan jobs
// can wait while the receiver stalls. A stalled output item holds.
// The APB port holds power_on_id at address 0; a write also reloads the ID.
// Reset clears the slot counter, digits, scan position and queue, and loads
// the ID "00".
module addressed_display_frame_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  adfc_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output adfc_pkg::out_item_t   out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [adfc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0]       power_on_id_reg;
    adfc_pkg::cfg_wr_t cfg;
    logic              q_full;
    logic              push;
    adfc_pkg::job_t    push_job;
    logic              head_valid;
    adfc_pkg::job_t    head;
    logic              pop;

    // Register port.
    assign pready = 1'b1;
    assign cfg.en = psel && penable && pwrite && pready
                 && (paddr[2] == adfc_pkg::REG_POWER_ON_ID);
    assign cfg.id = pwdata[15:0];
    assign prdata = (paddr[2] == adfc_pkg::REG_POWER_ON_ID) ? {16'd0, power_on_id_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            power_on_id_reg <= adfc_pkg::ID_RESET;
        else if (cfg.en)
            power_on_id_reg <= cfg.id;
    end

    adfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    adfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    adfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the addressed display frame controller.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [adfc_pkg::PADDR_W-1:0] ADDR_POWER_ON_ID =
        {adfc_pkg::REG_POWER_ON_ID, 2'b00};
    localparam int FRAME_BYTES = 9;
    localparam int SETTLE_CYCLES = 10;

    // Segment patterns of digits zero to nine.
    localparam logic [7:0] SEG_LUT [10] = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
                                            8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6};

    // One row of the directed table; tick rows carry their scan output.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       typed;
        logic [7:0] seg;
        logic [3:0] sel;
    } stim_row_t;

    localparam int DIR_ROWS = 24;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // First tick after reset shows digit zero on the first position.
        '{adfc_pkg::OP_TICK, 8'h00, 1'b1, 8'hFC, 4'hE},
        // Bad first bytes at both extremes.
        '{adfc_pkg::OP_BYTE, 8'h00, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'hFF, 1'b0, 8'h00, 4'h0},
        // Display frame for ID "00": digits 9, ten, wrapped value, 5.
        '{adfc_pkg::OP_BYTE, adfc_pkg::HDR_BYTE, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h30, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h30, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::CMD_DISPLAY, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h39, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h3A, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h00, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h35, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::END_BYTE, 1'b0, 8'h00, 4'h0},
        // Values above nine are blank; the last digit shows a five.
        '{adfc_pkg::OP_TICK, 8'h00, 1'b1, 8'h00, 4'hD},
        '{adfc_pkg::OP_TICK, 8'h00, 1'b1, 8'h00, 4'hB},
        '{adfc_pkg::OP_TICK, 8'h00, 1'b1, 8'hB6, 4'h7},
        // Set-ID frame with all-zero data: takes ID "AB" and echoes.
        '{adfc_pkg::OP_BYTE, adfc_pkg::HDR_BYTE, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h41, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, 8'h42, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::CMD_SET_ID, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::ASCII_ZERO, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::ASCII_ZERO, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::ASCII_ZERO, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::ASCII_ZERO, 1'b0, 8'h00, 4'h0},
        '{adfc_pkg::OP_BYTE, adfc_pkg::END_BYTE, 1'b0, 8'h00, 4'h0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    adfc_pkg::in_item_t            in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    adfc_pkg::out_item_t           out_item;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [adfc_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Mirror of the controller state.
    logic [7:0]  frame_mirror [FRAME_BYTES];
    logic [3:0]  slot_mirror = '0;
    logic [15:0] id_mirror = adfc_pkg::ID_RESET;
    logic [7:0]  digit_mirror [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [1:0]  scan_mirror = '0;

    adfc_pkg::out_item_t out_items_due [$];
    int                  err_cnt = 0;
    int                  burst_left = 0;

    addressed_display_frame_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    // Push the nine reply bytes of the frame now held in the mirror.
    task automatic queue_reply_frame();
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            out_items_due.push_back('{adfc_pkg::KIND_TX, frame_mirror[k], 8'h00,
                                      adfc_pkg::SEL_NONE, (k == FRAME_BYTES - 1)});
        end
    endtask

    // Act on a complete frame held in the mirror.
    task automatic decode_mirror_frame();
        logic       id_hit;
        logic       all_zero;
        logic [7:0] cmd;
        cmd = frame_mirror[3];
        id_hit = ({frame_mirror[1], frame_mirror[2]} == id_mirror);
        all_zero = (frame_mirror[4] == adfc_pkg::ASCII_ZERO) &&
                   (frame_mirror[5] == adfc_pkg::ASCII_ZERO) &&
                   (frame_mirror[6] == adfc_pkg::ASCII_ZERO) &&
                   (frame_mirror[7] == adfc_pkg::ASCII_ZERO);
        if (frame_mirror[0] != adfc_pkg::HDR_BYTE || frame_mirror[8] != adfc_pkg::END_BYTE)
            return;
        if (cmd == adfc_pkg::CMD_DISPLAY)
        begin
            if (id_hit)
                for (int i = 0; i < 4; i++)
                    digit_mirror[i] = frame_mirror[4 + i] - adfc_pkg::ASCII_ZERO;
            return;
        end
        if (cmd != adfc_pkg::CMD_SET_ID)
            return;
        if (all_zero)
        begin
            id_mirror = {frame_mirror[1], frame_mirror[2]};
            queue_reply_frame();
            return;
        end
        if (!id_hit)
            return;
        // Change of ID: the reply confirms the new address.
        id_mirror = {frame_mirror[6], frame_mirror[7]};
        frame_mirror[0] = adfc_pkg::HDR_BYTE;
        frame_mirror[1] = id_mirror[15:8];
        frame_mirror[2] = id_mirror[7:0];
        for (int i = 4; i < 8; i++)
            frame_mirror[i] = adfc_pkg::ASCII_ZERO;
        frame_mirror[8] = adfc_pkg::END_BYTE;
        queue_reply_frame();
    endtask

    // Advance the mirror by one accepted item and queue what it causes.
    task automatic advance_controller(adfc_pkg::in_item_t it);
        logic [7:0] v;
        logic [7:0] seg;
        logic [3:0] sel;
        if (it.op == adfc_pkg::OP_TICK)
        begin
            v = digit_mirror[scan_mirror];
            seg = (v <= 8'd9) ? SEG_LUT[v] : 8'h00;
            sel = ~(4'b0001 << scan_mirror);
            scan_mirror = scan_mirror + 2'd1;
            out_items_due.push_back('{adfc_pkg::KIND_SCAN, 8'h00, seg, sel, 1'b1});
            return;
        end
        if (slot_mirror >= FRAME_BYTES)
            slot_mirror = '0;
        frame_mirror[slot_mirror] = it.rx_byte;
        slot_mirror = slot_mirror + 4'd1;
        if (frame_mirror[0] != adfc_pkg::HDR_BYTE)
            slot_mirror = '0;
        if (slot_mirror == FRAME_BYTES)
        begin
            slot_mirror = '0;
            decode_mirror_frame();
        end
    endtask

    // Offer one item in bursts with random gaps; update the mirror when taken.
    task automatic send_item(adfc_pkg::in_item_t it, logic typed,
                             adfc_pkg::out_item_t typed_res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        advance_controller(it);
        if (typed)
            out_items_due[out_items_due.size() - 1] = typed_res;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item('{adfc_pkg::OP_BYTE, b}, 1'b0, '0);
    endtask

    task automatic send_tick();
        send_item('{adfc_pkg::OP_TICK, 8'($urandom_range(0, 255))}, 1'b0, '0);
    endtask

    // Random traffic: mostly frames with random content, plus ticks and noise.
    task automatic run_traffic(int n_items);
        int          sent;
        int          pick;
        int          len;
        logic [7:0]  f [FRAME_BYTES];
        logic [15:0] id;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                send_tick();
                sent++;
            end
            else if (pick < 25)
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                id = (pick < 70) ? id_mirror :
                     (pick < 85) ? id_mirror ^ (16'h0001 << $urandom_range(0, 15)) :
                     16'($urandom_range(0, 65535));
                f[0] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                       adfc_pkg::HDR_BYTE;
                f[1] = id[15:8];
                f[2] = id[7:0];
                pick = $urandom_range(0, 99);
                f[3] = (pick < 40) ? adfc_pkg::CMD_DISPLAY :
                       (pick < 80) ? adfc_pkg::CMD_SET_ID :
                       8'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                for (int i = 4; i < 8; i++)
                begin
                    if (f[3] == adfc_pkg::CMD_DISPLAY)
                        f[i] = ($urandom_range(0, 9) < 9) ?
                               adfc_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)) :
                               8'($urandom_range(0, 255));
                    else if (f[3] == adfc_pkg::CMD_SET_ID && pick < 35)
                        f[i] = adfc_pkg::ASCII_ZERO;
                    else
                        f[i] = 8'($urandom_range(0, 255));
                end
                f[8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                       adfc_pkg::END_BYTE;
                // A few frames break off early.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : FRAME_BYTES;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_tick();
                    send_byte(f[i]);
                end
                sent += len;
            end
        end
        in_valid <= 1'b0;
    endtask

    // Wait until every expected item has come out, then let the block settle.
    task automatic wait_drained();
        while (out_items_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic read_id_check(logic [15:0] expected_id);
        logic [31:0] d;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_POWER_ON_ID;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        d = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (d[15:0] !== expected_id)
        begin
            $display("%0t: power_on_id read expected %h actual %h", $time, expected_id,
                     d[15:0]);
            err_cnt++;
        end
    endtask

    // Write power_on_id; the device ID follows it.
    task automatic write_id(logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_POWER_ON_ID;
        pwdata <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        id_mirror = v;
        @(posedge clk);
        read_id_check(v);
    endtask

    task automatic check_field(string name, logic [7:0] expected_v, logic [7:0] actual_v);
        if (expected_v !== actual_v)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, expected_v, actual_v);
            err_cnt++;
        end
    endtask

    // Receiver stall pattern: a new random mode whenever the phase counter wraps.
    int       stall_phase = 0;
    int       stall_mode = 0;
    always @(posedge clk)
    begin
        if (stall_phase == 0)
            stall_mode <= $urandom_range(0, 3);
        stall_phase <= (stall_phase == 49) ? 0 : stall_phase + 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_phase[0];
        endcase
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        adfc_pkg::out_item_t exp_item;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (out_items_due.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, out_item);
                err_cnt++;
            end
            else
            begin
                exp_item = out_items_due.pop_front();
                check_field("kind", 8'(exp_item.kind), 8'(out_item.kind));
                check_field("tx_byte", exp_item.tx_byte, out_item.tx_byte);
                check_field("segments", exp_item.segments, out_item.segments);
                check_field("digit_select", 8'(exp_item.digit_select),
                            8'(out_item.digit_select));
                check_field("last", 8'(exp_item.last), 8'(out_item.last));
            end
        end
    end

    // Main sequence.
    initial
    begin
        adfc_pkg::out_item_t typed_res;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mirror[i] = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_id_check(adfc_pkg::ID_RESET);

        // Directed table, followed directly by random traffic.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            typed_res = '{adfc_pkg::KIND_SCAN, 8'h00, DIR_TABLE[r].seg, DIR_TABLE[r].sel,
                          1'b1};
            send_item('{DIR_TABLE[r].op, DIR_TABLE[r].data}, DIR_TABLE[r].typed, typed_res);
        end
        run_traffic(20);
        wait_drained();

        // Further ID settings, extremes first.
        write_id(16'h0000);
        run_traffic(25);
        wait_drained();
        write_id(16'hFFFF);
        run_traffic(25);
        wait_drained();
        write_id(16'($urandom_range(0, 65535)));
        run_traffic(25);
        wait_drained();

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Timeout.
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
